@@ rtl/core/mstk_pkg.sv @@
// Package: shared types, constants and controller states for the Kruskal MST unit.
`timescale 1ns / 1ps
package mstk_pkg;

   localparam int MaxVerticesDefault = 64;
   localparam int MaxEdgesDefault    = 256;
   localparam int WeightBitsDefault  = 16;
   localparam int VertexBits         = 6;
   localparam int CountBits          = 7;

   typedef struct packed {
      logic [VertexBits-1:0]        src_vertex;
      logic [VertexBits-1:0]        dst_vertex;
      logic signed [WeightBitsDefault-1:0] edge_weight;
      logic                         last_edge;
   } req_payload_type;

   typedef struct packed {
      logic [VertexBits-1:0]        tree_low_vertex;
      logic [VertexBits-1:0]        tree_high_vertex;
      logic signed [WeightBitsDefault-1:0] tree_weight;
      logic                         edge_valid;
      logic                         last_result;
      logic                         run_status;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SORT_RD,
      ST_SORT_WAIT,
      ST_SORT_CMP,
      ST_PAR_INIT,
      ST_SCAN_RD,
      ST_SCAN_WAIT,
      ST_SCAN_LOAD,
      ST_FIND,
      ST_EMIT,
      ST_STATUS,
      ST_DONE
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;        // store incoming edge
      logic sort_init;   // i=1, j=i
      logic sort_rd;     // read order[j-1], order[j]
      logic sort_swap;   // swap order[j-1], order[j], j--
      logic sort_next;   // i++, j=i
      logic par_init;    // parent[k]=k, k++
      logic scan_init;   // i=0, accepted=0
      logic scan_rd;     // read order[i] and edge
      logic scan_skip;   // i++
      logic find_start;  // load root walkers
      logic find_step;   // one parent step each
      logic link;        // parent[rs]=rd, accepted++, i++
      logic clear;       // end of run
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic store_full;
      logic sort_more;   // i < n
      logic sort_j_pos;  // j > 0
      logic sort_gt;     // w[order[j-1]] > w[order[j]]
      logic par_last;
      logic scan_more;   // i < n
      logic need_more;   // accepted < need
      logic need_zero;
      logic out_range;
      logic roots_done;
      logic roots_differ;
      logic last_accept; // accepted+1 == need
   } status_type;

endpackage

@@ rtl/core/mstk_datapath.sv @@
// Datapath: edge store, sort index memory, parent table and union-find walkers.
`timescale 1ns / 1ps
module mstk_datapath
   import mstk_pkg::*;
#(
   parameter int MAX_VERTICES = MaxVerticesDefault,
   parameter int MAX_EDGES    = MaxEdgesDefault,
   parameter int WEIGHT_BITS  = WeightBitsDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output status_type                 status,
   input  logic [VertexBits-1:0]      in_src,
   input  logic [VertexBits-1:0]      in_dst,
   input  logic [WEIGHT_BITS-1:0]     in_weight,
   input  logic [CountBits-1:0]       vertex_count,
   output logic [VertexBits-1:0]      out_low,
   output logic [VertexBits-1:0]      out_high,
   output logic [WEIGHT_BITS-1:0]     out_weight
);

   localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EC = $clog2(MAX_EDGES + 1);
   localparam int VA = $clog2(MAX_VERTICES);

   // Edge store and order index memories.
   logic [VertexBits-1:0]  src_mem [MAX_EDGES];
   logic [VertexBits-1:0]  dst_mem [MAX_EDGES];
   logic [WEIGHT_BITS-1:0] wgt_mem [MAX_EDGES];
   logic [EA-1:0]          ord_mem [MAX_EDGES];
   logic [VertexBits-1:0]  parent_mem [MAX_VERTICES];

   logic [EC-1:0] loaded_ff, loaded_in;
   logic [EC-1:0] i_ff, i_in, j_ff, j_in;
   logic [VertexBits-1:0] acc_ff, acc_in;
   logic [VA:0] k_ff, k_in;
   logic [EA-1:0] oa_ff, ob_ff;
   logic [WEIGHT_BITS-1:0] wa_ff, wb_ff;
   logic [VertexBits-1:0] s_ff, d_ff, rs_ff, rd_ff, ps_ff, pd_ff;
   logic [WEIGHT_BITS-1:0] w_ff;

   logic [CountBits-1:0] vc;
   logic [VertexBits-1:0] need;
   logic [EA-1:0] ja, jm1, ia;

   assign vc   = (vertex_count == '0) ? CountBits'(1) :
                 (vertex_count > CountBits'(MAX_VERTICES)) ? CountBits'(MAX_VERTICES) :
                 vertex_count;
   assign need = VertexBits'(vc - CountBits'(1));
   assign ja   = EA'(j_ff);
   assign jm1  = EA'(j_ff - EC'(1));
   assign ia   = EA'(i_ff);

   // Counters.
   always_comb begin
      loaded_in = loaded_ff;
      i_in = i_ff;
      j_in = j_ff;
      acc_in = acc_ff;
      k_in = k_ff;
      if (cmd.load && loaded_ff < EC'(MAX_EDGES)) loaded_in = loaded_ff + EC'(1);
      if (cmd.sort_init) begin
         i_in = EC'(1);
         j_in = EC'(1);
         k_in = '0;
      end
      if (cmd.sort_swap) j_in = j_ff - EC'(1);
      if (cmd.sort_next) begin
         i_in = i_ff + EC'(1);
         j_in = i_ff + EC'(1);
      end
      if (cmd.par_init) k_in = k_ff + 1'b1;
      if (cmd.scan_init) begin
         i_in = '0;
         acc_in = '0;
      end
      if (cmd.scan_skip) i_in = i_ff + EC'(1);
      if (cmd.link) begin
         i_in = i_ff + EC'(1);
         acc_in = acc_ff + 1'b1;
      end
      if (cmd.clear) begin
         loaded_in = '0;
         acc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
         i_ff <= '0;
         j_ff <= '0;
         acc_ff <= '0;
         k_ff <= '0;
      end else begin
         loaded_ff <= loaded_in;
         i_ff <= i_in;
         j_ff <= j_in;
         acc_ff <= acc_in;
         k_ff <= k_in;
      end
   end

   // Edge store: written on load, read at the order entry being compared or scanned.
   always_ff @(posedge clock) begin
      if (cmd.load && loaded_ff < EC'(MAX_EDGES)) begin
         src_mem[EA'(loaded_ff)] <= in_src;
         dst_mem[EA'(loaded_ff)] <= in_dst;
         wgt_mem[EA'(loaded_ff)] <= in_weight;
      end
   end

   // Order memory: identity on load, pairwise swaps during sort.
   always_ff @(posedge clock) begin
      if (cmd.load && loaded_ff < EC'(MAX_EDGES)) ord_mem[EA'(loaded_ff)] <= EA'(loaded_ff);
      if (cmd.sort_swap) begin
         ord_mem[jm1] <= ob_ff;
         ord_mem[ja]  <= oa_ff;
      end
      if (cmd.sort_rd) begin
         oa_ff <= ord_mem[jm1];
         ob_ff <= ord_mem[ja];
      end
      if (cmd.scan_rd) oa_ff <= ord_mem[ia];
   end

   // Weight reads for the compare (registered from the order read registers) and edge fetch.
   always_ff @(posedge clock) begin
      wa_ff <= wgt_mem[oa_ff];
      wb_ff <= wgt_mem[ob_ff];
      s_ff  <= src_mem[oa_ff];
      d_ff  <= dst_mem[oa_ff];
      w_ff  <= wgt_mem[oa_ff];
   end

   // Parent table and root walkers; the parent of each walker is read registered.
   always_ff @(posedge clock) begin
      if (cmd.par_init) parent_mem[VA'(k_ff)] <= VertexBits'(k_ff);
      if (cmd.link) parent_mem[VA'(rs_ff)] <= rd_ff;
      if (cmd.find_start) begin
         rs_ff <= s_ff;
         rd_ff <= d_ff;
         ps_ff <= parent_mem[VA'(s_ff)];
         pd_ff <= parent_mem[VA'(d_ff)];
      end else if (cmd.find_step) begin
         rs_ff <= ps_ff;
         rd_ff <= pd_ff;
         ps_ff <= parent_mem[VA'(ps_ff)];
         pd_ff <= parent_mem[VA'(pd_ff)];
      end
   end

   always_comb begin
      status.store_full   = (loaded_ff >= EC'(MAX_EDGES));
      status.sort_more    = (i_ff < loaded_ff);
      status.sort_j_pos   = (j_ff != '0);
      status.sort_gt      = ($signed(wa_ff) > $signed(wb_ff));
      status.par_last     = (k_ff == (VA+1)'(MAX_VERTICES - 1));
      status.scan_more    = (i_ff < loaded_ff);
      status.need_more    = (acc_ff < need);
      status.need_zero    = (need == '0);
      status.out_range    = ({1'b0, s_ff} >= vc) || ({1'b0, d_ff} >= vc);
      status.roots_done   = (ps_ff == rs_ff) && (pd_ff == rd_ff);
      status.roots_differ = (rs_ff != rd_ff);
      status.last_accept  = ((acc_ff + 1'b1) == need);
   end

   assign out_low    = (s_ff < d_ff) ? s_ff : d_ff;
   assign out_high   = (s_ff < d_ff) ? d_ff : s_ff;
   assign out_weight = w_ff;

endmodule

@@ rtl/core/mstk_controller.sv @@
// Controller: sequences load, insertion sort, parent reset, scan and result output.
`timescale 1ns / 1ps
module mstk_controller
   import mstk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_edge,
   output logic       rsp_last,
   output logic       rsp_status,
   output cmd_type    cmd,
   input  status_type status
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_LOAD;
      else       state_ff <= state_in;
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      rsp_edge = 1'b0;
      rsp_last = 1'b0;
      rsp_status = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  cmd.sort_init = 1'b1;
                  state_in = ST_SORT_RD;
               end
            end
         end
         ST_SORT_RD: begin
            if (!status.sort_more) state_in = ST_PAR_INIT;
            else if (!status.sort_j_pos) cmd.sort_next = 1'b1;
            else begin
               cmd.sort_rd = 1'b1;
               state_in = ST_SORT_WAIT;
            end
         end
         ST_SORT_WAIT: begin
            // order entries are in, weights are being read
            state_in = ST_SORT_CMP;
         end
         ST_SORT_CMP: begin
            // weights of the two order entries are ready here
            if (status.sort_gt) cmd.sort_swap = 1'b1;
            else cmd.sort_next = 1'b1;
            state_in = ST_SORT_RD;
         end
         ST_PAR_INIT: begin
            cmd.par_init = 1'b1;
            if (status.par_last) begin
               cmd.scan_init = 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            if (!status.scan_more || !status.need_more) state_in = ST_STATUS;
            else begin
               cmd.scan_rd = 1'b1;
               state_in = ST_SCAN_WAIT;
            end
         end
         ST_SCAN_WAIT: begin
            // edge fields are being read from the store
            state_in = ST_SCAN_LOAD;
         end
         ST_SCAN_LOAD: begin
            state_in = ST_FIND;
            cmd.find_start = 1'b1;
         end
         ST_FIND: begin
            if (status.out_range) begin
               cmd.scan_skip = 1'b1;
               state_in = ST_SCAN_RD;
            end else if (!status.roots_done) cmd.find_step = 1'b1;
            else if (status.roots_differ) state_in = ST_EMIT;
            else begin
               cmd.scan_skip = 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            rsp_edge = 1'b1;
            rsp_last = status.last_accept;
            if (rsp_ready) begin
               cmd.link = 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_STATUS: begin
            if (!status.need_zero && !status.need_more) begin
               cmd.clear = 1'b1;
               state_in = ST_LOAD;
            end else begin
               rsp_valid = 1'b1;
               rsp_last = 1'b1;
               rsp_status = !status.need_zero;
               if (rsp_ready) begin
                  cmd.clear = 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

endmodule

@@ rtl/core/minimum_spanning_tree_kruskal_unit.sv @@
// Top level: Kruskal minimum spanning tree unit with handshake ports.
`timescale 1ns / 1ps
// Edges load at one per cycle until last_edge. Then req_ready drops while the unit
// runs an insertion sort over the edge store (order read, weight read, then compare
// for each step), resets the parent table one entry at a time, and scans edges with
// union-find root walks (one parent step per cycle for both endpoints).
// Each tree edge is presented on rsp_ and the scan holds until it is taken; a
// status-only result closes the run when no edge is needed or edges run out.
module minimum_spanning_tree_kruskal_unit
   import mstk_pkg::*;
#(
   parameter int MAX_VERTICES = MaxVerticesDefault,
   parameter int MAX_EDGES    = MaxEdgesDefault,
   parameter int WEIGHT_BITS  = WeightBitsDefault
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [CountBits-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;
   logic [CountBits-1:0] vcount_ff;
   logic rsp_edge, rsp_last, rsp_status;
   logic [VertexBits-1:0] lo, hi;
   logic [WEIGHT_BITS-1:0] w;

   // Vertex count register.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) vcount_ff <= CountBits'(64);
      else if (csr_valid) vcount_ff <= csr_data;
   end

   mstk_controller u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_last(req_payload.last_edge), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_edge(rsp_edge), .rsp_last(rsp_last), .rsp_status(rsp_status),
      .cmd(cmd), .status(status)
   );

   mstk_datapath #(
      .MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES), .WEIGHT_BITS(WEIGHT_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .in_src(req_payload.src_vertex), .in_dst(req_payload.dst_vertex),
      .in_weight(WEIGHT_BITS'(req_payload.edge_weight)),
      .vertex_count(vcount_ff),
      .out_low(lo), .out_high(hi), .out_weight(w)
   );

   // Status-only results carry zero edge fields.
   always_comb begin
      rsp_payload.tree_low_vertex  = rsp_edge ? lo : '0;
      rsp_payload.tree_high_vertex = rsp_edge ? hi : '0;
      rsp_payload.tree_weight      = rsp_edge ?
         WeightBitsDefault'($signed(w)) : '0;
      rsp_payload.edge_valid       = rsp_edge;
      rsp_payload.last_result      = rsp_last;
      rsp_payload.run_status       = rsp_status;
   end

endmodule
